// ----- rtl/hkf_pkg.sv -----
// Shared types, constants and saturation helpers for the horizontal Kalman filter.
// Used by every module of the block; depends on nothing.
package hkf_pkg;

  localparam int VW = 32;
  localparam int PW = 48;
  localparam int CW = 47;
  localparam int MW = 51;
  localparam int NCFG = 6;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_STEPS = PW + 32;

  localparam int CFG_TIME_STEP = 0;
  localparam int CFG_PROC_POS = 1;
  localparam int CFG_PROC_VEL = 2;
  localparam int CFG_MEAS_POS = 3;
  localparam int CFG_MEAS_VEL = 4;
  localparam int CFG_INIT_VAR = 5;

  localparam logic [CW-1:0] CFG_RESET [NCFG] = '{
    47'd134217728, 47'd1048576, 47'd67108864,
    47'd21474836480, 47'd4294967296, 47'd4294967296
  };

  localparam logic signed [MW-1:0] ONE_Q = 51'sd4294967296;

  typedef enum logic [1:0] {
    KIND_INIT,
    KIND_PROP,
    KIND_POS,
    KIND_VEL
  } kind_t;

  typedef enum logic [3:0] {
    STEP_INIT,
    STEP_PR_DP11,
    STEP_PR_POS,
    STEP_PR_VEL,
    STEP_PR_P00,
    STEP_PR_COMMIT,
    STEP_UP_SETUP,
    STEP_UP_KA,
    STEP_UP_KB,
    STEP_UP_POS,
    STEP_UP_VEL,
    STEP_UP_N0,
    STEP_UP_N1,
    STEP_UP_N2,
    STEP_UP_N3,
    STEP_UP_COMMIT
  } step_t;

  typedef struct packed {
    kind_t kind;
    step_t step;
    logic  axis;
    logic  load;
    logic  exec;
    logic  mul_start;
    logic  div_start;
    logic  emit;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic skip;
  } sts_t;

  function automatic logic ovf32(input logic signed [51:0] v);
    return (v > 52'sd2147483647) || (v < -52'sd2147483648);
  endfunction

  function automatic logic signed [31:0] clip32(input logic signed [51:0] v);
    if (v > 52'sd2147483647) return 32'sh7fffffff;
    else if (v < -52'sd2147483648) return 32'sh80000000;
    else return 32'(v);
  endfunction

  function automatic logic ovf48(input logic signed [51:0] v);
    return (v > 52'sd140737488355327) || (v < -52'sd140737488355328);
  endfunction

  function automatic logic signed [47:0] clip48(input logic signed [51:0] v);
    if (v > 52'sd140737488355327) return 48'sh7fffffffffff;
    else if (v < -52'sd140737488355328) return 48'sh800000000000;
    else return 48'(v);
  endfunction

endpackage

// ----- rtl/hkf_mul.sv -----
// Multi-cycle signed fixed-point multiplier: round(a*b / 2^32), saturated to 48 bits.
// Four 26x26 partial products; depends on hkf_pkg.
module hkf_mul (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [hkf_pkg::MW-1:0]   a,
  input  logic signed [hkf_pkg::MW-1:0]   b,
  output logic                            done,
  output logic signed [hkf_pkg::PW-1:0]   result,
  output logic                            sat
);

  localparam int HW = 26;

  logic             busy;
  logic [2:0]       cnt;
  logic             neg;
  logic [2*HW-1:0]  ma;
  logic [2*HW-1:0]  mb;
  logic [2*HW-1:0]  pp;
  logic [6:0]       pp_sh;
  logic [4*HW-1:0]  acc;

  logic [hkf_pkg::MW-1:0] ua;
  logic [hkf_pkg::MW-1:0] ub;
  logic [HW-1:0]    pa;
  logic [HW-1:0]    pb;
  logic [4*HW-1:0]  rsum;
  logic [4*HW-33:0] q;

  always_comb begin
    ua = a[hkf_pkg::MW-1] ? (~a + 1'b1) : a;
    ub = b[hkf_pkg::MW-1] ? (~b + 1'b1) : b;
    pa = cnt[1] ? ma[2*HW-1:HW] : ma[HW-1:0];
    pb = cnt[0] ? mb[2*HW-1:HW] : mb[HW-1:0];
    rsum = acc + 104'd2147483648;
    q = rsum[4*HW-1:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        neg <= a[hkf_pkg::MW-1] ^ b[hkf_pkg::MW-1];
        ma <= (2*HW)'(ua);
        mb <= (2*HW)'(ub);
        acc <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt < 3'd4) begin
          pp <= pa * pb;
          pp_sh <= (cnt[1] ? 7'(HW) : 7'd0) + (cnt[0] ? 7'(HW) : 7'd0);
        end
        if (cnt != 3'd0 && cnt <= 3'd4) begin
          acc <= acc + ((4*HW)'(pp) << pp_sh);
        end
        if (cnt == 3'd5) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (neg) begin
            sat <= q > 72'd140737488355328;
            result <= (q > 72'd140737488355328) ? 48'sh800000000000 : -$signed(48'(q));
          end else begin
            sat <= q > 72'd140737488355327;
            result <= (q > 72'd140737488355327) ? 48'sh7fffffffffff : $signed(48'(q));
          end
        end
      end
    end
  end

endmodule

// ----- rtl/hkf_div.sv -----
// Restoring bit-serial divider: round(num * 2^32 / den), saturated to 48 bits.
// One quotient bit per cycle; depends on hkf_pkg.
module hkf_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [hkf_pkg::PW-1:0]   num,
  input  logic [hkf_pkg::PW-1:0]          den,
  output logic                            done,
  output logic signed [hkf_pkg::PW-1:0]   result,
  output logic                            sat
);

  localparam int NW = hkf_pkg::DIV_STEPS;

  logic          busy;
  logic [6:0]    cnt;
  logic          neg;
  logic [hkf_pkg::PW-1:0] dd;
  logic [hkf_pkg::PW-1:0] rem;
  logic [NW-1:0] work;

  logic [hkf_pkg::PW:0]   t;
  logic          ge;
  logic          inc;
  logic [NW:0]   q;

  always_comb begin
    t = {rem, work[NW-1]};
    ge = t >= {1'b0, dd};
    inc = {rem, 1'b0} >= {1'b0, dd};
    q = (NW+1)'(work) + (NW+1)'(inc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        neg <= num[hkf_pkg::PW-1];
        dd <= den;
        rem <= '0;
        work <= {(num[hkf_pkg::PW-1] ? (~num + 1'b1) : num), 32'd0};
      end else if (busy) begin
        if (cnt < 7'(NW)) begin
          cnt <= cnt + 7'd1;
          rem <= ge ? hkf_pkg::PW'(t - {1'b0, dd}) : t[hkf_pkg::PW-1:0];
          work <= {work[NW-2:0], ge};
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
          if (neg) begin
            sat <= q > 81'd140737488355328;
            result <= (q > 81'd140737488355328) ? 48'sh800000000000 : -$signed(48'(q));
          end else begin
            sat <= q > 81'd140737488355327;
            result <= (q > 81'd140737488355327) ? 48'sh7fffffffffff : $signed(48'(q));
          end
        end
      end
    end
  end

endmodule

// ----- rtl/hkf_dp.sv -----
// Filter datapath: configuration, per-axis state and covariance, operand selection.
// Instantiates hkf_mul and hkf_div; steered by hkf_ctrl through hkf_pkg::cmd_t.
module hkf_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [hkf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hkf_pkg::CW-1:0]              cfg_data,
  input  logic [127:0]                        in_data,
  input  hkf_pkg::cmd_t                       cmd,
  output hkf_pkg::sts_t                       sts,
  output logic [221:0]                        out_data,
  output logic                                out_sat
);

  logic [hkf_pkg::CW-1:0]         cfg [hkf_pkg::NCFG];
  logic signed [31:0]             pos [2];
  logic signed [31:0]             vel [2];
  logic signed [31:0]             meas [2];
  logic signed [31:0]             ivel [2];
  logic signed [47:0]             pmat [2][4];
  logic signed [47:0]             np [4];
  logic signed [47:0]             dp11;
  logic signed [32:0]             res;
  logic [47:0]                    sden;
  logic signed [47:0]             ka;
  logic signed [47:0]             kb;
  logic                           skip;
  logic                           sat;

  logic                           ax;
  logic signed [47:0]             pc [4];
  logic signed [31:0]             pos_c;
  logic signed [31:0]             vel_c;
  logic signed [31:0]             meas_c;
  logic [1:0]                     ni;
  logic                           is_pos;
  logic                           direct;
  logic signed [47:0]             g;
  logic signed [50:0]             inner;
  logic signed [50:0]             dt_s;
  logic signed [50:0]             mul_a;
  logic signed [50:0]             mul_b;
  logic signed [47:0]             div_num;
  logic                           mul_done;
  logic signed [47:0]             mres;
  logic                           msat;
  logic                           div_done;
  logic signed [47:0]             dres;
  logic                           dsat;
  logic signed [51:0]             sum_pos;
  logic signed [51:0]             sum_vel;
  logic signed [51:0]             sum_p00;
  logic signed [51:0]             sum_sub;
  logic signed [49:0]             s_sum;

  always_comb begin
    ax = cmd.axis;
    for (int k = 0; k < 4; k++) pc[k] = pmat[ax][k];
    pos_c = pos[ax];
    vel_c = vel[ax];
    meas_c = meas[ax];
    ni = 2'(cmd.step - hkf_pkg::STEP_UP_N0);
    is_pos = cmd.kind == hkf_pkg::KIND_POS;
    direct = is_pos ? !ni[1] : ni[1];
    g = ni[1] ? kb : ka;
    inner = 51'(pc[1]) + 51'(pc[2]) + 51'(dp11);
    dt_s = $signed(51'(cfg[hkf_pkg::CFG_TIME_STEP]));
    sum_pos = 52'(pos_c) + 52'(mres);
    sum_vel = 52'(vel_c) + 52'(mres);
    sum_p00 = 52'(pc[0]) + 52'(mres) + $signed(52'(cfg[hkf_pkg::CFG_PROC_POS]));
    sum_sub = 52'(pc[ni]) - 52'(mres);
    s_sum = is_pos ? 50'(pc[0]) + $signed(50'(cfg[hkf_pkg::CFG_MEAS_POS]))
                   : 50'(pc[3]) + $signed(50'(cfg[hkf_pkg::CFG_MEAS_VEL]));
    mul_a = '0;
    mul_b = '0;
    case (cmd.step) inside
      hkf_pkg::STEP_PR_DP11: begin
        mul_a = dt_s;
        mul_b = 51'(pc[3]);
      end
      hkf_pkg::STEP_PR_POS: begin
        mul_a = dt_s;
        mul_b = 51'(vel_c);
      end
      hkf_pkg::STEP_PR_VEL: begin
        mul_a = dt_s;
        mul_b = 51'(meas_c);
      end
      hkf_pkg::STEP_PR_P00: begin
        mul_a = dt_s;
        mul_b = inner;
      end
      hkf_pkg::STEP_UP_POS: begin
        mul_a = 51'(ka);
        mul_b = 51'(res);
      end
      hkf_pkg::STEP_UP_VEL: begin
        mul_a = 51'(kb);
        mul_b = 51'(res);
      end
      hkf_pkg::STEP_UP_N0, hkf_pkg::STEP_UP_N1, hkf_pkg::STEP_UP_N2, hkf_pkg::STEP_UP_N3: begin
        mul_a = direct ? (hkf_pkg::ONE_Q - 51'(g)) : 51'(g);
        mul_b = direct ? 51'(pc[ni]) : 51'(pc[ni ^ 2'd2]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    if (cmd.step == hkf_pkg::STEP_UP_KA) div_num = is_pos ? pc[0] : pc[1];
    else div_num = is_pos ? pc[2] : pc[3];
  end

  hkf_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mres),
    .sat    (msat)
  );

  hkf_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.div_start),
    .num    (div_num),
    .den    (sden),
    .done   (div_done),
    .result (dres),
    .sat    (dsat)
  );

  assign sts.mul_done = mul_done;
  assign sts.div_done = div_done;
  assign sts.skip = skip;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < hkf_pkg::NCFG; i++) cfg[i] <= hkf_pkg::CFG_RESET[i];
      for (int a = 0; a < 2; a++) begin
        pos[a] <= '0;
        vel[a] <= '0;
        pmat[a][0] <= $signed({1'b0, hkf_pkg::CFG_RESET[hkf_pkg::CFG_INIT_VAR]});
        pmat[a][1] <= '0;
        pmat[a][2] <= '0;
        pmat[a][3] <= $signed({1'b0, hkf_pkg::CFG_RESET[hkf_pkg::CFG_INIT_VAR]});
      end
      skip <= 1'b0;
      sat <= 1'b0;
      out_sat <= 1'b0;
    end else begin
      if (cfg_we && cfg_index < hkf_pkg::CFG_IDX_W'(hkf_pkg::NCFG)) cfg[cfg_index] <= cfg_data;

      if (cmd.load) begin
        meas[0] <= $signed(in_data[31:0]);
        meas[1] <= $signed(in_data[63:32]);
        ivel[0] <= $signed(in_data[95:64]);
        ivel[1] <= $signed(in_data[127:96]);
        sat <= 1'b0;
      end

      if (mul_done) begin
        case (cmd.step) inside
          hkf_pkg::STEP_PR_DP11: begin
            dp11 <= mres;
            sat <= sat | msat;
          end
          hkf_pkg::STEP_PR_POS, hkf_pkg::STEP_UP_POS: begin
            pos[ax] <= hkf_pkg::clip32(sum_pos);
            sat <= sat | msat | hkf_pkg::ovf32(sum_pos);
          end
          hkf_pkg::STEP_PR_VEL, hkf_pkg::STEP_UP_VEL: begin
            vel[ax] <= hkf_pkg::clip32(sum_vel);
            sat <= sat | msat | hkf_pkg::ovf32(sum_vel);
          end
          hkf_pkg::STEP_PR_P00: begin
            np[0] <= hkf_pkg::clip48(sum_p00);
            sat <= sat | msat | hkf_pkg::ovf48(sum_p00);
          end
          hkf_pkg::STEP_UP_N0, hkf_pkg::STEP_UP_N1, hkf_pkg::STEP_UP_N2, hkf_pkg::STEP_UP_N3: begin
            np[ni] <= direct ? mres : hkf_pkg::clip48(sum_sub);
            sat <= sat | msat | (!direct && hkf_pkg::ovf48(sum_sub));
          end
          default: sat <= sat | msat;
        endcase
      end

      if (div_done) begin
        if (cmd.step == hkf_pkg::STEP_UP_KA) ka <= dres;
        else kb <= dres;
        sat <= sat | dsat;
      end

      if (cmd.exec) begin
        unique case (cmd.step) inside
          hkf_pkg::STEP_INIT: begin
            for (int a = 0; a < 2; a++) begin
              pos[a] <= meas[a];
              vel[a] <= ivel[a];
              pmat[a][0] <= $signed({1'b0, cfg[hkf_pkg::CFG_INIT_VAR]});
              pmat[a][1] <= '0;
              pmat[a][2] <= '0;
              pmat[a][3] <= $signed({1'b0, cfg[hkf_pkg::CFG_INIT_VAR]});
            end
          end
          hkf_pkg::STEP_PR_COMMIT: begin
            pmat[ax][0] <= np[0];
            pmat[ax][1] <= hkf_pkg::clip48(52'(pc[1]) + 52'(dp11));
            pmat[ax][2] <= hkf_pkg::clip48(52'(pc[2]) + 52'(dp11));
            pmat[ax][3] <= hkf_pkg::clip48(52'(pc[3])
                           + $signed(52'(cfg[hkf_pkg::CFG_PROC_VEL])));
            sat <= sat | hkf_pkg::ovf48(52'(pc[1]) + 52'(dp11))
                       | hkf_pkg::ovf48(52'(pc[2]) + 52'(dp11))
                       | hkf_pkg::ovf48(52'(pc[3])
                                        + $signed(52'(cfg[hkf_pkg::CFG_PROC_VEL])));
          end
          hkf_pkg::STEP_UP_SETUP: begin
            res <= 33'(meas_c) - 33'(is_pos ? pos_c : vel_c);
            skip <= s_sum <= 50'sd0;
            sden <= 48'(s_sum);
            if (s_sum <= 50'sd0) sat <= 1'b1;
          end
          hkf_pkg::STEP_UP_COMMIT: begin
            for (int k = 0; k < 4; k++) pmat[ax][k] <= np[k];
          end
          default: ;
        endcase
      end

      if (cmd.emit) begin
        out_data[31:0] <= pos[0];
        out_data[63:32] <= vel[0];
        out_data[95:64] <= pos[1];
        out_data[127:96] <= vel[1];
        out_data[174:128] <= pmat[0][0][47] ? 47'd0 : pmat[0][0][46:0];
        out_data[221:175] <= pmat[1][0][47] ? 47'd0 : pmat[1][0][46:0];
        out_sat <= sat | pmat[0][0][47] | pmat[1][0][47];
      end
    end
  end

endmodule

// ----- rtl/hkf_ctrl.sv -----
// Filter sequencer: walks the step list of each item kind over both axes.
// Drives hkf_dp through hkf_pkg::cmd_t and owns the input and output handshakes.
module hkf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  hkf_pkg::kind_t      kind_in,
  input  logic                m_tready,
  output logic                m_tvalid,
  input  hkf_pkg::sts_t       sts,
  output hkf_pkg::cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT_MUL,
    S_WAIT_DIV,
    S_CHECK,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    CL_MUL,
    CL_DIV,
    CL_EXEC
  } op_cls_t;

  state_t          state;
  hkf_pkg::step_t  step;
  hkf_pkg::kind_t  kind;
  logic            axis;
  logic            out_valid;

  op_cls_t         cls;
  hkf_pkg::step_t  step_succ;
  state_t          ea_state;
  logic            ea_axis;
  hkf_pkg::step_t  ea_step;

  function automatic hkf_pkg::step_t first_step(input hkf_pkg::kind_t k);
    unique case (k)
      hkf_pkg::KIND_INIT: return hkf_pkg::STEP_INIT;
      hkf_pkg::KIND_PROP: return hkf_pkg::STEP_PR_DP11;
      default:            return hkf_pkg::STEP_UP_SETUP;
    endcase
  endfunction

  always_comb begin
    unique case (step) inside
      hkf_pkg::STEP_UP_KA, hkf_pkg::STEP_UP_KB: cls = CL_DIV;
      hkf_pkg::STEP_INIT, hkf_pkg::STEP_PR_COMMIT, hkf_pkg::STEP_UP_SETUP,
      hkf_pkg::STEP_UP_COMMIT: cls = CL_EXEC;
      default: cls = CL_MUL;
    endcase
    step_succ = hkf_pkg::step_t'(step + 4'd1);
    if (kind == hkf_pkg::KIND_INIT || axis) begin
      ea_state = S_EMIT;
      ea_axis = axis;
      ea_step = step;
    end else begin
      ea_state = S_ISSUE;
      ea_axis = 1'b1;
      ea_step = first_step(kind);
    end
    s_tready = state == S_IDLE;
    m_tvalid = out_valid;
    cmd.kind = kind;
    cmd.step = step;
    cmd.axis = axis;
    cmd.load = s_tvalid && s_tready;
    cmd.exec = state == S_ISSUE && cls == CL_EXEC;
    cmd.mul_start = state == S_ISSUE && cls == CL_MUL;
    cmd.div_start = state == S_ISSUE && cls == CL_DIV;
    cmd.emit = state == S_EMIT && (!out_valid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= hkf_pkg::STEP_INIT;
      kind <= hkf_pkg::KIND_INIT;
      axis <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd.load) begin
            kind <= kind_in;
            axis <= 1'b0;
            step <= first_step(kind_in);
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          unique case (cls)
            CL_MUL: state <= S_WAIT_MUL;
            CL_DIV: state <= S_WAIT_DIV;
            default: begin
              if (step == hkf_pkg::STEP_UP_SETUP) begin
                state <= S_CHECK;
              end else begin
                state <= ea_state;
                axis <= ea_axis;
                step <= ea_step;
              end
            end
          endcase
        end
        S_WAIT_MUL: begin
          if (sts.mul_done) begin
            step <= step_succ;
            state <= S_ISSUE;
          end
        end
        S_WAIT_DIV: begin
          if (sts.div_done) begin
            step <= step_succ;
            state <= S_ISSUE;
          end
        end
        S_CHECK: begin
          if (sts.skip) begin
            state <= ea_state;
            axis <= ea_axis;
            step <= ea_step;
          end else begin
            step <= hkf_pkg::STEP_UP_KA;
            state <= S_ISSUE;
          end
        end
        S_EMIT: begin
          if (cmd.emit) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mul_start && cmd.div_start))
    else $error("multiplier and divider started together");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is in work");

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result overwrote an untaken transaction");

  a_wait_mul: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_start |=> state == S_WAIT_MUL)
    else $error("multiply issued without waiting for it");

endmodule

// ----- rtl/horizontal_kalman_filter.sv -----
// Top level of the two-axis position/velocity Kalman filter.
// Joins hkf_ctrl and hkf_dp; depends on hkf_pkg.
//
// One item is in work at a time; a finished result waits in the output register
// while the next item is taken. A propagate runs eight multiplies on the shared
// partial-product multiplier. A position or speed update computes four gains from
// the one-bit-per-cycle divider, plus twelve multiplies; an axis whose innovation
// variance is not positive skips its gains and multiplies. Configuration writes
// take effect at once.
module horizontal_kalman_filter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [hkf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hkf_pkg::CW-1:0]            cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // x_value, y_value, x_init_velocity, y_init_velocity
  input  logic [127:0]                      s_tdata,
  // kind
  input  logic [1:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // x_position, x_velocity, y_position, y_velocity, x_position_variance,
  // y_position_variance, zero fill
  output logic [223:0]                      m_tdata,
  // saturated
  output logic                              m_tuser
);

  hkf_pkg::cmd_t cmd;
  hkf_pkg::sts_t sts;
  logic [221:0]  out_data;

  hkf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .kind_in  (hkf_pkg::kind_t'(s_tuser)),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .sts      (sts),
    .cmd      (cmd)
  );

  hkf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data),
    .out_sat   (m_tuser)
  );

  assign m_tdata = {2'b00, out_data};

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for horizontal_kalman_filter: drives init, propagate and update transactions,
// predicts each result in a scoreboard class and checks it field by field. Depends on hkf_pkg.
module tb;

  localparam longint LIM32 = 64'sd2147483647;
  localparam longint LIM48 = 64'sd140737488355327;
  localparam longint ONE_Q32 = 64'sd4294967296;
  localparam logic [hkf_pkg::CW-1:0] CFG_MAX = {hkf_pkg::CW{1'b1}};
  localparam int CFG_UNUSED = 6;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;

  typedef struct {
    logic [31:0] x_pos, x_vel, y_pos, y_vel;
    logic [hkf_pkg::CW-1:0] x_var, y_var;
    logic sat;
  } estimate_t;

  class kf_scoreboard;
    logic [hkf_pkg::CW-1:0] regs [hkf_pkg::NCFG];
    longint pos [2], vel [2];
    longint cov [2][4];
    bit sat;
    estimate_t pending [$];
    int errors;

    function new();
      for (int i = 0; i < hkf_pkg::NCFG; i++) regs[i] = hkf_pkg::CFG_RESET[i];
      for (int a = 0; a < 2; a++) init_axis(a, 0, 0);
      errors = 0;
    endfunction

    function void write_reg(int idx, logic [hkf_pkg::CW-1:0] v);
      if (idx < hkf_pkg::NCFG) regs[idx] = v;
    endfunction

    function longint clampv(longint v, longint lim);
      if (v > lim) begin
        sat = 1;
        return lim;
      end
      if (v < -lim - 1) begin
        sat = 1;
        return -lim - 1;
      end
      return v;
    endfunction

    function longint mulq(longint a, longint b);
      bit neg;
      logic [127:0] ua, ub, q;
      neg = (a < 0) != (b < 0);
      ua = a < 0 ? 128'(-a) : 128'(a);
      ub = b < 0 ? 128'(-b) : 128'(b);
      q = (ua * ub + (128'd1 << 31)) >> 32;
      if (neg) begin
        if (q > 128'(LIM48 + 1)) begin
          sat = 1;
          return -LIM48 - 1;
        end
        return -longint'(q);
      end
      if (q > 128'(LIM48)) begin
        sat = 1;
        return LIM48;
      end
      return longint'(q);
    endfunction

    function longint divq(longint num, longint den);
      bit neg;
      logic [127:0] un, q, r;
      neg = num < 0;
      un = (neg ? 128'(-num) : 128'(num)) << 32;
      q = un / 128'(den);
      r = un % 128'(den);
      if (q <= 128'(LIM48 + 1) && 2 * r >= 128'(den)) q++;
      if (neg) begin
        if (q > 128'(LIM48 + 1)) begin
          sat = 1;
          return -LIM48 - 1;
        end
        return -longint'(q);
      end
      if (q > 128'(LIM48)) begin
        sat = 1;
        return LIM48;
      end
      return longint'(q);
    endfunction

    function void init_axis(int a, longint ip, longint iv);
      pos[a] = ip;
      vel[a] = iv;
      cov[a][0] = longint'(regs[hkf_pkg::CFG_INIT_VAR]);
      cov[a][1] = 0;
      cov[a][2] = 0;
      cov[a][3] = longint'(regs[hkf_pkg::CFG_INIT_VAR]);
    endfunction

    function void propagate_axis(int a, longint acc);
      longint dt, dp11, inner, n0, n1, n2, n3, oldv;
      dt = longint'(regs[hkf_pkg::CFG_TIME_STEP]);
      dp11 = mulq(dt, cov[a][3]);
      inner = cov[a][2] + cov[a][1] + dp11;
      oldv = vel[a];
      pos[a] = clampv(pos[a] + mulq(dt, oldv), LIM32);
      vel[a] = clampv(oldv + mulq(dt, acc), LIM32);
      n0 = clampv(cov[a][0] + mulq(dt, inner) + longint'(regs[hkf_pkg::CFG_PROC_POS]), LIM48);
      n1 = clampv(cov[a][1] + dp11, LIM48);
      n2 = clampv(cov[a][2] + dp11, LIM48);
      n3 = clampv(cov[a][3] + longint'(regs[hkf_pkg::CFG_PROC_VEL]), LIM48);
      cov[a] = '{n0, n1, n2, n3};
    endfunction

    function void update_axis(int a, bit speed, longint meas);
      longint res, s, k1, k2, n0, n1, n2, n3;
      longint p0, p1, p2, p3;
      p0 = cov[a][0];
      p1 = cov[a][1];
      p2 = cov[a][2];
      p3 = cov[a][3];
      res = meas - (speed ? vel[a] : pos[a]);
      s = speed ? p3 + longint'(regs[hkf_pkg::CFG_MEAS_VEL])
                : p0 + longint'(regs[hkf_pkg::CFG_MEAS_POS]);
      if (s <= 0) begin
        sat = 1;
        return;
      end
      k1 = divq(speed ? p1 : p0, s);
      k2 = divq(speed ? p3 : p2, s);
      pos[a] = clampv(pos[a] + mulq(k1, res), LIM32);
      vel[a] = clampv(vel[a] + mulq(k2, res), LIM32);
      if (speed) begin
        n0 = clampv(p0 - mulq(k1, p2), LIM48);
        n1 = clampv(p1 - mulq(k1, p3), LIM48);
        n2 = clampv(mulq(ONE_Q32 - k2, p2), LIM48);
        n3 = clampv(mulq(ONE_Q32 - k2, p3), LIM48);
      end else begin
        n0 = clampv(mulq(ONE_Q32 - k1, p0), LIM48);
        n1 = clampv(mulq(ONE_Q32 - k1, p1), LIM48);
        n2 = clampv(p2 - mulq(k2, p0), LIM48);
        n3 = clampv(p3 - mulq(k2, p1), LIM48);
      end
      cov[a] = '{n0, n1, n2, n3};
    endfunction

    function logic [hkf_pkg::CW-1:0] var_out(longint v);
      if (v < 0) begin
        sat = 1;
        return '0;
      end
      return v[hkf_pkg::CW-1:0];
    endfunction

    function void note_input(hkf_pkg::kind_t kind, logic [127:0] d);
      longint v [2];
      estimate_t e;
      v[0] = longint'($signed(d[31:0]));
      v[1] = longint'($signed(d[63:32]));
      sat = 0;
      for (int a = 0; a < 2; a++) begin
        case (kind)
          hkf_pkg::KIND_INIT: init_axis(a, v[a], longint'($signed(d[64 + 32*a +: 32])));
          hkf_pkg::KIND_PROP: propagate_axis(a, v[a]);
          hkf_pkg::KIND_POS: update_axis(a, 0, v[a]);
          default: update_axis(a, 1, v[a]);
        endcase
      end
      e.x_pos = pos[0][31:0];
      e.x_vel = vel[0][31:0];
      e.y_pos = pos[1][31:0];
      e.y_vel = vel[1][31:0];
      e.x_var = var_out(cov[0][0]);
      e.y_var = var_out(cov[1][0]);
      e.sat = sat;
      pending.push_back(e);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(logic [223:0] d, logic u);
      estimate_t e;
      if (pending.size() == 0) begin
        report("unexpected transaction", 64'(d[31:0]), 64'd0);
      end else begin
        e = pending.pop_front();
        if (d[31:0] !== e.x_pos) report("x_position", 64'(d[31:0]), 64'(e.x_pos));
        if (d[63:32] !== e.x_vel) report("x_velocity", 64'(d[63:32]), 64'(e.x_vel));
        if (d[95:64] !== e.y_pos) report("y_position", 64'(d[95:64]), 64'(e.y_pos));
        if (d[127:96] !== e.y_vel) report("y_velocity", 64'(d[127:96]), 64'(e.y_vel));
        if (d[174:128] !== e.x_var) report("x_position_variance", 64'(d[174:128]), 64'(e.x_var));
        if (d[221:175] !== e.y_var) report("y_position_variance", 64'(d[221:175]), 64'(e.y_var));
        if (d[223:222] !== 2'b00) report("zero fill", 64'(d[223:222]), 64'd0);
        if (u !== e.sat) report("saturated", 64'(u), 64'(e.sat));
      end
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [hkf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [hkf_pkg::CW-1:0] cfg_data = '0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [127:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [223:0] m_tdata;
  logic m_tuser;

  kf_scoreboard sb = new();
  bit hold_req = 0;
  bit calm = 0;
  int idle_cycles = 0;

  horizontal_kalman_filter dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int gap;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        gap = HOLD_CYCLES;
      end else begin
        gap = calm ? 0 : $urandom_range(0, 8);
      end
      if (gap > 0) begin
        m_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  task send(hkf_pkg::kind_t kind, logic [31:0] xv, logic [31:0] yv, logic [31:0] xi,
            logic [31:0] yi);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= kind;
    s_tdata <= {yi, xi, yv, xv};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(kind, s_tdata);
  endtask

  task drain();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task write_reg(int idx, logic [hkf_pkg::CW-1:0] v);
    cfg_we <= 1;
    cfg_index <= idx[hkf_pkg::CFG_IDX_W-1:0];
    cfg_data <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  task write_all(logic [hkf_pkg::CW-1:0] v [hkf_pkg::NCFG]);
    for (int i = 0; i < hkf_pkg::NCFG; i++) write_reg(i, v[i]);
    write_reg(CFG_UNUSED, CFG_MAX);
    cfg_we <= 0;
  endtask

  function logic [31:0] rand_value();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 2097152)) - 1048576);
  endfunction

  task random_items(int count);
    hkf_pkg::kind_t kind;
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 2) == 0);
      kind = hkf_pkg::kind_t'($urandom_range(0, 3));
      send(kind, rand_value(), rand_value(), rand_value(), rand_value());
    end
    calm = 0;
  endtask

  initial begin
    logic [hkf_pkg::CW-1:0] v [hkf_pkg::NCFG];
    repeat (3) @(posedge clk);
    rst <= 0;

    // reset state first, then extremes of every field for each kind
    send(hkf_pkg::KIND_PROP, 32'h0001_0000, 32'hffff_0000, '0, '0);
    send(hkf_pkg::KIND_POS, 32'h0002_0000, 32'hfffe_0000, '0, '0);
    send(hkf_pkg::KIND_VEL, 32'h0000_8000, 32'h8000_0000, '0, '0);
    send(hkf_pkg::KIND_INIT, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send(hkf_pkg::KIND_PROP, 32'h7fff_ffff, 32'h8000_0000, '0, '0);
    send(hkf_pkg::KIND_POS, 32'h8000_0000, 32'h7fff_ffff, '0, '0);
    send(hkf_pkg::KIND_VEL, 32'h8000_0000, 32'h7fff_ffff, '0, '0);
    send(hkf_pkg::KIND_INIT, '0, '0, '0, '0);
    send(hkf_pkg::KIND_PROP, '0, '0, '0, '0);
    send(hkf_pkg::KIND_POS, 32'h0010_0000, 32'hfff0_0000, '0, '0);
    send(hkf_pkg::KIND_VEL, 32'h0003_0000, 32'hfffd_0000, '0, '0);
    drain();

    // zero noise and zero init variance: innovation variance not positive, gains forced off
    v = '{hkf_pkg::CFG_RESET[0], '0, '0, '0, '0, '0};
    write_all(v);
    send(hkf_pkg::KIND_INIT, 32'h0001_0000, 32'h0002_0000, 32'h0000_1000, 32'hffff_f000);
    send(hkf_pkg::KIND_POS, 32'h0005_0000, 32'h0005_0000, '0, '0);
    send(hkf_pkg::KIND_VEL, 32'h0005_0000, 32'h0005_0000, '0, '0);
    send(hkf_pkg::KIND_PROP, 32'h0001_0000, 32'h0001_0000, '0, '0);
    send(hkf_pkg::KIND_POS, 32'h0005_0000, 32'hfffb_0000, '0, '0);
    drain();

    // init variance written late takes effect at the next init only
    write_reg(hkf_pkg::CFG_INIT_VAR, 47'd8589934592);
    cfg_we <= 0;
    send(hkf_pkg::KIND_PROP, '0, '0, '0, '0);
    send(hkf_pkg::KIND_INIT, 32'h0001_0000, 32'h0001_0000, '0, '0);
    send(hkf_pkg::KIND_VEL, 32'h0002_0000, 32'h0002_0000, '0, '0);
    drain();

    v = hkf_pkg::CFG_RESET;
    write_all(v);
    random_items(300);
    drain();

    for (int i = 0; i < hkf_pkg::NCFG; i++) v[i] = 47'($urandom_range(0, 32'h7fff_ffff)) << 4;
    write_all(v);
    hold_req = 1;
    random_items(300);
    drain();

    v = '{CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX};
    write_all(v);
    random_items(150);
    drain();

    v = '{'0, '0, '0, '0, '0, '0};
    write_all(v);
    random_items(150);
    drain();

    for (int i = 0; i < hkf_pkg::NCFG; i++) v[i] = hkf_pkg::CW'({$urandom, $urandom});
    write_all(v);
    random_items(300);
    drain();

    if (sb.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

// ----- horizontal_kalman_filter.f -----
rtl/hkf_pkg.sv
rtl/hkf_mul.sv
rtl/hkf_div.sv
rtl/hkf_dp.sv
rtl/hkf_ctrl.sv
rtl/horizontal_kalman_filter.sv
dv/tb.sv
